FILE: hdl/dgcd_pkg.sv
// shared types and constants of the directed graph cycle detector
package dgcd_pkg;

  localparam int MAX_NODES = 64;
  localparam int ROW_W     = $clog2(MAX_NODES);
  localparam int NODE_W    = 6;
  localparam int COUNT_W   = 7;
  localparam int ROW_BITS  = 64;
  localparam int STACK_D   = 64;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_CHECK = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_ROOT,
    ST_EVAL,
    ST_POP
  } state_t;

  typedef struct packed {
    logic                clear;
    logic                rd;
    logic [ROW_W-1:0]    rd_addr;
    logic                wr;
    logic [ROW_W-1:0]    wr_addr;
    logic [ROW_BITS-1:0] wr_data;
  } edge_req_t;

endpackage

FILE: hdl/dgcd_edge_store.sv
// adjacency matrix memory with per-row valid bits so that a clear empties every row at once
module dgcd_edge_store (
  input  logic                          clk,
  input  logic                          rst,
  input  dgcd_pkg::edge_req_t           req,
  output logic [dgcd_pkg::ROW_BITS-1:0] rd_data
);

  logic [dgcd_pkg::ROW_BITS-1:0]  mem [dgcd_pkg::MAX_NODES];
  logic [dgcd_pkg::MAX_NODES-1:0] row_valid;
  logic [dgcd_pkg::ROW_BITS-1:0]  rd_q;
  logic                           rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  // rows never written since the last clear read as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (req.clear) begin
        row_valid <= '0;
      end else if (req.wr) begin
        row_valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd) begin
        rd_valid <= row_valid[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

FILE: hdl/directed_graph_cycle_detector_top.sv
// directed graph cycle detector: edge memory, dfs stack memory and search control
// clear takes effect at its transfer; add edge keeps busy high for one cycle (read, write)
// check: done strobes once the search ends, each step paced by the registered reads of
//   the edge row memory and stack memory
// one command at a time; the receiver cannot stall, done is high for one cycle
// synchronous reset empties the graph, sets node_count to 64 and returns to idle
module directed_graph_cycle_detector_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   command,
  input  logic [dgcd_pkg::NODE_W-1:0]  from_node,
  input  logic [dgcd_pkg::NODE_W-1:0]  to_node,
  input  logic                         cfg_write,
  input  logic [dgcd_pkg::COUNT_W-1:0] cfg_data,
  output logic                         done,
  output logic                         cycle_found
);

  dgcd_pkg::state_t state, state_next;

  logic [dgcd_pkg::COUNT_W-1:0]  node_count;
  logic [dgcd_pkg::COUNT_W-1:0]  n_eff;
  logic [dgcd_pkg::ROW_BITS-1:0] mask;

  // search marks and stack pointer
  logic [dgcd_pkg::ROW_BITS-1:0] seen, seen_next;
  logic [dgcd_pkg::ROW_BITS-1:0] onpath, onpath_next;
  logic [dgcd_pkg::COUNT_W-1:0]  depth, depth_next;
  logic [dgcd_pkg::COUNT_W-1:0]  root, root_next;
  logic [dgcd_pkg::NODE_W-1:0]   top, top_next;
  logic                          done_next;
  logic                          found_next;

  // pending add edge
  logic [dgcd_pkg::ROW_W-1:0]    add_row;
  logic [dgcd_pkg::NODE_W-1:0]   add_col;
  logic                          add_ok;

  // stack memory
  logic [dgcd_pkg::NODE_W-1:0]   stack_mem [dgcd_pkg::STACK_D];
  logic                          stack_we;
  logic [dgcd_pkg::NODE_W-1:0]   stack_waddr;
  logic [dgcd_pkg::NODE_W-1:0]   stack_wdata;
  logic [dgcd_pkg::COUNT_W-1:0]  pop_idx;
  logic [dgcd_pkg::NODE_W-1:0]   stack_rdata;

  // edge memory interface
  dgcd_pkg::edge_req_t           req;
  logic [dgcd_pkg::ROW_BITS-1:0] rd_data;

  // evaluation of the row fetched for the top of stack
  logic                          accept;
  logic [dgcd_pkg::ROW_BITS-1:0] row;
  logic [dgcd_pkg::ROW_BITS-1:0] fresh;
  logic                          hit;
  logic                          any_fresh;
  logic [dgcd_pkg::NODE_W-1:0]   first_fresh;
  logic                          root_end;

  dgcd_edge_store u_edge_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  assign busy   = (state != dgcd_pkg::ST_IDLE);
  assign accept = start & ~busy;

  // node count saturates at the matrix size
  assign n_eff = (node_count > dgcd_pkg::COUNT_W'(dgcd_pkg::MAX_NODES)) ?
                 dgcd_pkg::COUNT_W'(dgcd_pkg::MAX_NODES) : node_count;
  assign mask  = n_eff[dgcd_pkg::COUNT_W-1] ? '1 :
                 ((dgcd_pkg::ROW_BITS'(1) << n_eff[dgcd_pkg::NODE_W-1:0])
                  - dgcd_pkg::ROW_BITS'(1));

  assign row       = rd_data & mask;
  assign hit       = |(row & onpath);          // back edge onto the current path
  assign fresh     = row & ~seen;
  assign any_fresh = |fresh;
  assign root_end  = (root >= n_eff);
  assign pop_idx   = depth - dgcd_pkg::COUNT_W'(2);

  // lowest unvisited successor
  always_comb begin
    first_fresh = '0;
    for (int i = dgcd_pkg::ROW_BITS - 1; i >= 0; i--) begin
      if (fresh[i]) begin
        first_fresh = dgcd_pkg::NODE_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dgcd_pkg::ST_IDLE: begin
        if (accept) begin
          case (command)
            dgcd_pkg::CMD_ADD:   state_next = dgcd_pkg::ST_ADD;
            dgcd_pkg::CMD_CHECK: state_next = dgcd_pkg::ST_ROOT;
            default:             state_next = dgcd_pkg::ST_IDLE;
          endcase
        end
      end
      dgcd_pkg::ST_ADD: state_next = dgcd_pkg::ST_IDLE;
      dgcd_pkg::ST_ROOT: begin
        if (root_end) begin
          state_next = dgcd_pkg::ST_IDLE;
        end else if (!seen[root[dgcd_pkg::NODE_W-1:0]]) begin
          state_next = dgcd_pkg::ST_EVAL;
        end
      end
      dgcd_pkg::ST_EVAL: begin
        if (hit) begin
          state_next = dgcd_pkg::ST_IDLE;
        end else if (any_fresh) begin
          state_next = dgcd_pkg::ST_EVAL;
        end else if (depth == dgcd_pkg::COUNT_W'(1)) begin
          state_next = dgcd_pkg::ST_ROOT;
        end else begin
          state_next = dgcd_pkg::ST_POP;
        end
      end
      dgcd_pkg::ST_POP: state_next = dgcd_pkg::ST_EVAL;
      default:          state_next = dgcd_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    seen_next   = seen;
    onpath_next = onpath;
    depth_next  = depth;
    root_next   = root;
    top_next    = top;
    done_next   = 1'b0;
    found_next  = cycle_found;
    stack_we    = 1'b0;
    stack_waddr = depth[dgcd_pkg::NODE_W-1:0];
    stack_wdata = '0;
    req         = '0;
    case (state)
      dgcd_pkg::ST_IDLE: begin
        if (accept) begin
          case (command)
            dgcd_pkg::CMD_CLEAR: req.clear = 1'b1;
            dgcd_pkg::CMD_ADD: begin
              // fetch the source row for read-modify-write
              req.rd      = 1'b1;
              req.rd_addr = from_node[dgcd_pkg::ROW_W-1:0];
            end
            dgcd_pkg::CMD_CHECK: begin
              seen_next   = '0;
              onpath_next = '0;
              depth_next  = '0;
              root_next   = '0;
            end
            default: ;
          endcase
        end
      end
      dgcd_pkg::ST_ADD: begin
        if (add_ok) begin
          req.wr      = 1'b1;
          req.wr_addr = add_row;
          req.wr_data = rd_data | (dgcd_pkg::ROW_BITS'(1) << add_col);
        end
      end
      dgcd_pkg::ST_ROOT: begin
        if (root_end) begin
          done_next  = 1'b1;
          found_next = 1'b0;
        end else if (!seen[root[dgcd_pkg::NODE_W-1:0]]) begin
          // push the root and fetch its row
          stack_we    = 1'b1;
          stack_wdata = root[dgcd_pkg::NODE_W-1:0];
          depth_next  = depth + dgcd_pkg::COUNT_W'(1);
          seen_next   = seen | (dgcd_pkg::ROW_BITS'(1) << root[dgcd_pkg::NODE_W-1:0]);
          onpath_next = onpath | (dgcd_pkg::ROW_BITS'(1) << root[dgcd_pkg::NODE_W-1:0]);
          top_next    = root[dgcd_pkg::NODE_W-1:0];
          req.rd      = 1'b1;
          req.rd_addr = root[dgcd_pkg::ROW_W-1:0];
        end else begin
          root_next = root + dgcd_pkg::COUNT_W'(1);
        end
      end
      dgcd_pkg::ST_EVAL: begin
        if (hit) begin
          done_next  = 1'b1;
          found_next = 1'b1;
        end else if (any_fresh) begin
          // descend into the lowest unvisited successor
          stack_we    = 1'b1;
          stack_wdata = first_fresh;
          depth_next  = depth + dgcd_pkg::COUNT_W'(1);
          seen_next   = seen | (dgcd_pkg::ROW_BITS'(1) << first_fresh);
          onpath_next = onpath | (dgcd_pkg::ROW_BITS'(1) << first_fresh);
          top_next    = first_fresh;
          req.rd      = 1'b1;
          req.rd_addr = first_fresh[dgcd_pkg::ROW_W-1:0];
        end else begin
          // node finished: leave the path and pop
          onpath_next = onpath & ~(dgcd_pkg::ROW_BITS'(1) << top);
          depth_next  = depth - dgcd_pkg::COUNT_W'(1);
          if (depth == dgcd_pkg::COUNT_W'(1)) begin
            root_next = root + dgcd_pkg::COUNT_W'(1);
          end
        end
      end
      dgcd_pkg::ST_POP: begin
        // new top arrives from the stack memory, fetch its row
        top_next    = stack_rdata;
        req.rd      = 1'b1;
        req.rd_addr = stack_rdata[dgcd_pkg::ROW_W-1:0];
      end
      default: ;
    endcase
  end

  // stack memory, read always points one below the top
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    stack_rdata <= stack_mem[pop_idx[dgcd_pkg::NODE_W-1:0]];
  end

  // captured add edge operands
  always_ff @(posedge clk) begin
    if (accept) begin
      add_row <= from_node[dgcd_pkg::ROW_W-1:0];
      add_col <= to_node;
      add_ok  <= ({1'b0, from_node} < n_eff) && ({1'b0, to_node} < n_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dgcd_pkg::ST_IDLE;
      node_count  <= dgcd_pkg::COUNT_W'(64);
      seen        <= '0;
      onpath      <= '0;
      depth       <= '0;
      root        <= '0;
      top         <= '0;
      done        <= 1'b0;
      cycle_found <= 1'b0;
    end else begin
      state       <= state_next;
      seen        <= seen_next;
      onpath      <= onpath_next;
      depth       <= depth_next;
      root        <= root_next;
      top         <= top_next;
      done        <= done_next;
      cycle_found <= found_next;
      if (cfg_write) begin
        node_count <= cfg_data;
      end
    end
  end

  // a result only ends a check
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding check");

  // every node on the path is also marked visited
  a_path_in_seen: assert property (@(posedge clk) disable iff (rst)
    (onpath & ~seen) == '0)
    else $error("on-path mark without visited mark");

  // rows are only evaluated with a non-empty stack
  a_eval_depth: assert property (@(posedge clk) disable iff (rst)
    (state == dgcd_pkg::ST_EVAL) |-> (depth != '0))
    else $error("evaluation with empty stack");

  // stack never grows past the node range
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= dgcd_pkg::COUNT_W'(dgcd_pkg::MAX_NODES))
    else $error("stack overflow");

endmodule

FILE: bench/directed_graph_cycle_detector_top_test.sv
// self-checking bench for the directed graph cycle detector: directed cases, then random graphs
module directed_graph_cycle_detector_top_test;

  // command code that the block must ignore
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  // watchdog, far above the slowest correct run
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // quiet cycles after the last result, above the longest check
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned MAX_MISMATCH_PRINTS = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] command = dgcd_pkg::CMD_CLEAR;
  logic [dgcd_pkg::NODE_W-1:0] from_node = '0;
  logic [dgcd_pkg::NODE_W-1:0] to_node = '0;
  logic cfg_write = 1'b0;
  logic [dgcd_pkg::COUNT_W-1:0] cfg_data = '0;
  logic done;
  logic cycle_found;

  // bench copy of the block state
  logic [dgcd_pkg::ROW_BITS-1:0] graph_rows [dgcd_pkg::MAX_NODES];
  logic [dgcd_pkg::COUNT_W-1:0] node_cfg;
  // predicted cycle_found of every check transfer still owed by the block
  bit expected_cycle [$];

  int unsigned sender_idle_pct = 0;
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned checks_seen = 0;
  int unsigned cycles_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycle_count = 0;

  directed_graph_cycle_detector_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .from_node  (from_node),
    .to_node    (to_node),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .done       (done),
    .cycle_found(cycle_found)
  );

  // period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // node count in effect: saturates at the matrix size, zero means no node in use
  function automatic logic [dgcd_pkg::COUNT_W-1:0] eff_nodes();
    return (node_cfg > dgcd_pkg::COUNT_W'(dgcd_pkg::MAX_NODES)) ?
           dgcd_pkg::COUNT_W'(dgcd_pkg::MAX_NODES) : node_cfg;
  endfunction

  // iterative dfs over the nodes in use: roots ascending, children by lowest bit first
  function automatic bit predict_cycle();
    logic [dgcd_pkg::NODE_W-1:0] path_stack [dgcd_pkg::STACK_D];
    logic [dgcd_pkg::ROW_BITS-1:0] mask;
    logic [dgcd_pkg::ROW_BITS-1:0] seen;
    logic [dgcd_pkg::ROW_BITS-1:0] on_path;
    logic [dgcd_pkg::ROW_BITS-1:0] row;
    logic [dgcd_pkg::ROW_BITS-1:0] fresh;
    logic [dgcd_pkg::COUNT_W-1:0] n;
    logic [dgcd_pkg::COUNT_W-1:0] depth;
    logic [dgcd_pkg::COUNT_W-1:0] root;
    logic [dgcd_pkg::NODE_W-1:0] top;
    logic [dgcd_pkg::NODE_W-1:0] child;
    n = eff_nodes();
    mask = n[dgcd_pkg::COUNT_W-1] ? '1 :
           ((dgcd_pkg::ROW_BITS'(1) << n[dgcd_pkg::NODE_W-1:0]) - dgcd_pkg::ROW_BITS'(1));
    seen = '0;
    on_path = '0;
    for (root = '0; root < n; root++) begin
      if (seen[root[dgcd_pkg::NODE_W-1:0]]) continue;
      path_stack[0] = root[dgcd_pkg::NODE_W-1:0];
      depth = dgcd_pkg::COUNT_W'(1);
      seen[root[dgcd_pkg::NODE_W-1:0]] = 1'b1;
      on_path[root[dgcd_pkg::NODE_W-1:0]] = 1'b1;
      while (depth != '0) begin
        top = path_stack[dgcd_pkg::NODE_W'(depth - dgcd_pkg::COUNT_W'(1))];
        row = graph_rows[top] & mask;
        // an edge back onto the current path closes a cycle
        if ((row & on_path) != '0) return 1'b1;
        fresh = row & ~seen;
        if (fresh != '0) begin
          child = '0;
          for (int i = dgcd_pkg::ROW_BITS - 1; i >= 0; i--) begin
            if (fresh[i]) child = dgcd_pkg::NODE_W'(i);
          end
          path_stack[depth[dgcd_pkg::NODE_W-1:0]] = child;
          depth = depth + dgcd_pkg::COUNT_W'(1);
          seen[child] = 1'b1;
          on_path[child] = 1'b1;
        end else begin
          on_path[top] = 1'b0;
          depth = depth - dgcd_pkg::COUNT_W'(1);
        end
      end
    end
    return 1'b0;
  endfunction

  // follows every transfer into the block and checks every result it gives
  always @(posedge clk) begin : watch_transfers
    bit want;
    logic [dgcd_pkg::COUNT_W-1:0] n;
    if (rst) begin
      for (int r = 0; r < dgcd_pkg::MAX_NODES; r++) graph_rows[r] = '0;
      node_cfg = 7'd64;
      expected_cycle.delete();
    end else begin
      if (done) begin
        if (expected_cycle.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_MISMATCH_PRINTS)
            $display("%0t: unexpected result, none pending: expected none, actual %0b",
                     $time, cycle_found);
        end else begin
          want = expected_cycle.pop_front();
          checks_seen++;
          if (want) cycles_seen++;
          if (cycle_found !== want) begin
            fail_count++;
            if (fail_count <= MAX_MISMATCH_PRINTS)
              $display("%0t: cycle_found mismatch: expected %0b, actual %0b",
                       $time, want, cycle_found);
          end
        end
      end
      if (cfg_write) node_cfg = cfg_data;
      if (start && !busy) begin
        n = eff_nodes();
        case (command)
          dgcd_pkg::CMD_CLEAR: begin
            for (int r = 0; r < dgcd_pkg::MAX_NODES; r++) graph_rows[r] = '0;
          end
          dgcd_pkg::CMD_ADD: begin
            // edges touching a node outside the count in use are dropped
            if ({1'b0, from_node} < n && {1'b0, to_node} < n)
              graph_rows[from_node][to_node] = 1'b1;
          end
          dgcd_pkg::CMD_CHECK: begin
            expected_cycle = {expected_cycle, predict_cycle()};
          end
          default: begin
            // reserved code, no effect
          end
        endcase
      end
    end
  end

  // one command transfer, after a random idle gap; start stays high until the next gap
  task automatic send_cmd(input logic [1:0] cmd, input int unsigned src, input int unsigned dst);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk) start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    command <= cmd;
    from_node <= src[dgcd_pkg::NODE_W-1:0];
    to_node <= dst[dgcd_pkg::NODE_W-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // drop start and wait until every owed result is in and the block is idle
  task automatic settle();
    @(negedge clk) start <= 1'b0;
    while (expected_cycle.size() != 0 || busy) @(posedge clk);
    // an add edge may still be finishing its write
    repeat (8) @(posedge clk);
  endtask

  // node_count write, only while idle
  task automatic write_node_count(input int unsigned value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value[dgcd_pkg::COUNT_W-1:0];
    @(negedge clk) cfg_write <= 1'b0;
    cfg_writes++;
  endtask

  // empty graph, self loop at the top node, a three-node ring, the reserved code
  task automatic test_basic_cycles();
    send_cmd(dgcd_pkg::CMD_CHECK, 0, 0);
    send_cmd(dgcd_pkg::CMD_ADD, 63, 63);
    send_cmd(dgcd_pkg::CMD_CHECK, 63, 0);
    send_cmd(dgcd_pkg::CMD_CLEAR, 63, 63);
    send_cmd(dgcd_pkg::CMD_ADD, 0, 1);
    send_cmd(dgcd_pkg::CMD_ADD, 1, 2);
    send_cmd(dgcd_pkg::CMD_CHECK, 0, 0);
    send_cmd(dgcd_pkg::CMD_ADD, 2, 0);
    send_cmd(dgcd_pkg::CMD_CHECK, 0, 0);
    send_cmd(dgcd_pkg::CMD_CLEAR, 0, 0);
    // reserved code must not add the edge nor answer
    send_cmd(CMD_RESERVED, 63, 63);
    send_cmd(dgcd_pkg::CMD_CHECK, 63, 63);
    send_cmd(dgcd_pkg::CMD_ADD, 0, 63);
    send_cmd(dgcd_pkg::CMD_CHECK, 0, 0);
  endtask

  // zero nodes, saturated count, count lowered under stored edges, single node
  task automatic test_node_count_limits();
    settle();
    write_node_count(0);
    send_cmd(dgcd_pkg::CMD_ADD, 0, 0);
    send_cmd(dgcd_pkg::CMD_CHECK, 0, 0);
    settle();
    write_node_count(127);
    send_cmd(dgcd_pkg::CMD_CLEAR, 0, 0);
    send_cmd(dgcd_pkg::CMD_ADD, 63, 62);
    send_cmd(dgcd_pkg::CMD_ADD, 62, 63);
    send_cmd(dgcd_pkg::CMD_CHECK, 0, 0);
    settle();
    // ring through node 63 is stored but out of use now
    write_node_count(63);
    send_cmd(dgcd_pkg::CMD_CHECK, 0, 0);
    settle();
    write_node_count(1);
    send_cmd(dgcd_pkg::CMD_ADD, 0, 63);
    send_cmd(dgcd_pkg::CMD_CHECK, 0, 0);
    send_cmd(dgcd_pkg::CMD_ADD, 0, 0);
    send_cmd(dgcd_pkg::CMD_CHECK, 0, 0);
    settle();
    write_node_count(64);
  endtask

  // random graphs: mostly acyclic sets with an optional closing edge, some chains and noise
  task automatic test_random_graphs(input int unsigned idle_pct, input int unsigned budget);
    int unsigned stop_at;
    int unsigned graph_no;
    int unsigned pick;
    int unsigned span;
    int unsigned edges;
    int unsigned a;
    int unsigned b;
    sender_idle_pct = idle_pct;
    stop_at = items_sent + budget;
    graph_no = 0;
    while (items_sent < stop_at) begin
      // new node count every third graph; settling first also drains all results
      if (graph_no % 3 == 0) begin
        settle();
        pick = $urandom_range(99);
        if (pick < 5) write_node_count(0);
        else if (pick < 10) write_node_count($urandom_range(127, 65));
        else if (pick < 25) write_node_count(dgcd_pkg::MAX_NODES);
        else write_node_count($urandom_range(16, 1));
      end else if ($urandom_range(5) == 0) begin
        settle();
      end
      graph_no++;
      // with no node in use, fields still sweep the whole range and all edges drop
      span = (eff_nodes() == '0) ? dgcd_pkg::MAX_NODES : 32'(eff_nodes());
      pick = $urandom_range(9);
      if (pick == 0) begin
        // chain through every node: deepest search path, then closed into a ring
        send_cmd(dgcd_pkg::CMD_CLEAR, $urandom_range(63), $urandom_range(63));
        for (int unsigned i = 0; i + 1 < span; i++) send_cmd(dgcd_pkg::CMD_ADD, i, i + 1);
        send_cmd(dgcd_pkg::CMD_CHECK, $urandom_range(63), $urandom_range(63));
        send_cmd(dgcd_pkg::CMD_ADD, span - 1, 0);
        send_cmd(dgcd_pkg::CMD_CHECK, $urandom_range(63), $urandom_range(63));
      end else if (pick == 1) begin
        // noise: any code, any fields
        repeat ($urandom_range(8, 3))
          send_cmd(2'($urandom_range(3)), $urandom_range(63), $urandom_range(63));
        send_cmd(dgcd_pkg::CMD_CHECK, $urandom_range(63), $urandom_range(63));
      end else begin
        send_cmd(dgcd_pkg::CMD_CLEAR, $urandom_range(63), $urandom_range(63));
        edges = $urandom_range(12, 1);
        for (int unsigned e = 0; e < edges; e++) begin
          if ($urandom_range(9) == 0) begin
            // stray edge, often outside the nodes in use
            send_cmd(dgcd_pkg::CMD_ADD, $urandom_range(63), $urandom_range(63));
          end else begin
            a = $urandom_range(span - 1);
            b = $urandom_range(span - 1);
            // forward edges only keep the graph acyclic
            if (a < b) send_cmd(dgcd_pkg::CMD_ADD, a, b);
            else if (b < a) send_cmd(dgcd_pkg::CMD_ADD, b, a);
          end
        end
        send_cmd(dgcd_pkg::CMD_CHECK, $urandom_range(63), $urandom_range(63));
        if ($urandom_range(9) < 6) begin
          // backward edge or self loop, closes a cycle when a path already links them
          a = $urandom_range(span - 1);
          b = $urandom_range(a);
          send_cmd(dgcd_pkg::CMD_ADD, a, b);
          send_cmd(dgcd_pkg::CMD_CHECK, $urandom_range(63), $urandom_range(63));
        end
      end
    end
  endtask

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("directed_graph_cycle_detector_top_test failed");
    $finish;
  end

  initial begin
    // reset held from time zero, released on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_basic_cycles();
    test_node_count_limits();
    // sender idles with a chance of 30 percent before each transfer, then 58, then never
    test_random_graphs(30, 225);
    test_random_graphs(58, 225);
    test_random_graphs(0, 225);

    settle();
    // catch any stray result after the last one owed
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d command transfers and %0d node count writes", items_sent, cfg_writes);
    $display("checked %0d results, %0d of them reporting a cycle", checks_seen, cycles_seen);
    if (fail_count == 0 && expected_cycle.size() == 0) begin
      $display("directed_graph_cycle_detector_top_test passed");
    end else begin
      $display("directed_graph_cycle_detector_top_test failed");
    end
    $finish;
  end

endmodule

FILE: directed_graph_cycle_detector_top.f
hdl/dgcd_pkg.sv
hdl/dgcd_edge_store.sv
hdl/directed_graph_cycle_detector_top.sv
bench/directed_graph_cycle_detector_top_test.sv
